// ----- rtl/csm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants of the sparse matrix-vector block
// Request structs for both ports, the internal operation code, the queue
// entry passed from front to back, and the configuration register map.
// ----------------------------------------------------------------------------
package csm_pkg;

	// Input request kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_NZ   = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Configuration map: one 32-bit register, word address in paddr[2]
	localparam int unsigned CFG_AW           = 3;
	localparam logic        CFG_COLUMNS_IDX  = 1'b0;
	localparam logic [12:0] COLUMNS_RESET    = 13'd4096;

	// Queue depths between the parts
	localparam int unsigned MID_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 4;

	typedef struct packed {
		logic [1:0]         kind;
		logic [11:0]        index;
		logic signed [31:0] value;
	} csm_in_t;

	typedef struct packed {
		logic signed [31:0] row_sum;
		logic [15:0]        row_number;
		logic               saturated;
		logic               bad_column;
	} csm_out_t;

	// Operation classified by the front
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_MAC,
		OP_BAD,
		OP_END
	} csm_op_t;

	typedef struct packed {
		csm_op_t            op;
		logic signed [31:0] value;
		logic signed [31:0] vec;
	} csm_mid_t;

endpackage : csm_pkg
`default_nettype wire

// ----- rtl/csm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_queue: small register FIFO
// Circular buffer with occupancy count. Writers check count before pushing;
// the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module csm_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           head,
	output logic                            empty,
	output logic      [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign do_pop = pop && (count_q != '0);

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = entries_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule : csm_queue
`default_nettype wire

// ----- rtl/csm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_front: request intake, classification and vector store access
// Accepts input requests, sorts them into load / multiply-accumulate /
// skipped column / end of row (kind 3 is dropped), writes or reads the vector
// store and hands each operation to the middle queue in the next cycle.
// ----------------------------------------------------------------------------
module csm_front
	import csm_pkg::*;
#(
	parameter int unsigned COLUMNS = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire csm_in_t                        item,
	input  wire logic [12:0]                    cols,
	input  wire logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
	output logic                                full,
	output logic                                mid_push,
	output csm_mid_t                            mid_data
);

	// Only the first 4096 entries are reachable with a 12-bit index
	localparam int unsigned DEPTH = (COLUMNS < 4096) ? COLUMNS : 4096;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned MCW   = $clog2(MID_DEPTH+1);

	logic [31:0]        vec_mem_q [DEPTH];
	logic               valid_s1;
	csm_op_t            op_s1;
	logic signed [31:0] value_s1;
	logic signed [31:0] vec_s1;

	logic               accept;
	logic               in_range;
	logic               col_ok;
	logic               issue;
	csm_op_t            op_d;
	logic [AW-1:0]      addr;
	logic [MCW:0]       occupancy;

	// Room for the request in flight plus queued ones
	assign occupancy = {1'b0, mid_count} + (MCW+1)'(valid_s1);
	assign full      = (occupancy >= (MCW+1)'(MID_DEPTH));
	assign accept    = push && !full;
	assign addr      = item.index[AW-1:0];
	assign in_range  = (32'(item.index) < COLUMNS);
	assign col_ok    = in_range && ({1'b0, item.index} < cols);

	// Classify the request
	always_comb begin
		op_d  = OP_END;
		issue = 1'b0;
		unique case (item.kind)
			KIND_LOAD: begin
				op_d  = OP_LOAD;
				issue = 1'b1;
			end
			KIND_NZ: begin
				op_d  = col_ok ? OP_MAC : OP_BAD;
				issue = 1'b1;
			end
			KIND_END: begin
				op_d  = OP_END;
				issue = 1'b1;
			end
			default: begin
				// kind 3 is dropped
				op_d  = OP_END;
				issue = 1'b0;
			end
		endcase
	end

	// Vector store: at most one access per accepted request, read data registered
	always_ff @(posedge clk) begin
		if (accept && (item.kind == KIND_LOAD) && in_range) begin
			vec_mem_q[addr] <= item.value;
		end
		if (accept && (item.kind == KIND_NZ) && col_ok) begin
			vec_s1 <= signed'(vec_mem_q[addr]);
		end
		if (accept) begin
			value_s1 <= item.value;
			op_s1    <= op_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && issue;
		end
	end

	assign mid_push       = valid_s1;
	assign mid_data.op    = op_s1;
	assign mid_data.value = value_s1;
	assign mid_data.vec   = vec_s1;

endmodule : csm_front
`default_nettype wire

// ----- rtl/csm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_back: multiply-accumulate and row finish
// Pops operations from the middle queue, multiplies in one registered stage,
// then updates the row accumulator or rounds, saturates and pushes a result
// into the output queue.
// ----------------------------------------------------------------------------
module csm_back
	import csm_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire csm_mid_t                       mid_head,
	input  wire logic                           mid_empty,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                                mid_pop,
	output logic                                out_push,
	output csm_out_t                            out_data
);

	localparam int unsigned        OCW  = $clog2(OUT_DEPTH+1);
	localparam logic signed [63:0] HALF = signed'(64'((64'd1 << FRAC_BITS) >> 1));
	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

	logic               valid_s1;
	csm_op_t            op_s1;
	logic signed [63:0] prod_s1;

	logic signed [63:0] acc_q;
	logic [15:0]        row_q;
	logic               bad_q;

	logic [OCW:0]       out_used;
	logic signed [63:0] mac_sum;
	logic signed [63:0] rounded;
	logic signed [63:0] shifted;
	logic signed [31:0] clipped;
	logic               clip;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
	                                                 input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	// Pop only when the output queue can take every operation in flight
	assign out_used = {1'b0, out_count} + (OCW+1)'(valid_s1);
	assign mid_pop  = !mid_empty && (out_used < (OCW+1)'(OUT_DEPTH));

	// Multiply stage
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			op_s1   <= mid_head.op;
			prod_s1 <= mid_head.value * mid_head.vec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= mid_pop;
		end
	end

	// Accumulate and row finish
	always_comb begin
		mac_sum = sat_add64(acc_q, prod_s1);
		rounded = sat_add64(acc_q, HALF);
		shifted = rounded >>> FRAC_BITS;
		clip    = 1'b0;
		clipped = shifted[31:0];
		if (shifted > S32_MAX) begin
			clipped = 32'sh7fff_ffff;
			clip    = 1'b1;
		end else if (shifted < S32_MIN) begin
			clipped = 32'sh8000_0000;
			clip    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			row_q <= '0;
			bad_q <= 1'b0;
		end else if (valid_s1) begin
			unique case (op_s1)
				OP_LOAD: begin
					acc_q <= '0;
					row_q <= '0;
					bad_q <= 1'b0;
				end
				OP_MAC: begin
					acc_q <= mac_sum;
				end
				OP_BAD: begin
					bad_q <= 1'b1;
				end
				OP_END: begin
					acc_q <= '0;
					row_q <= row_q + 1'b1;
					bad_q <= 1'b0;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign out_push            = valid_s1 && (op_s1 == OP_END);
	assign out_data.row_sum    = clipped;
	assign out_data.row_number = row_q;
	assign out_data.saturated  = clip;
	assign out_data.bad_column = bad_q;

endmodule : csm_back
`default_nettype wire

// ----- rtl/csr_sparse_matvec_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matvec_top: sparse matrix times dense vector, compressed rows
// Front intake and vector store, middle queue, multiply-accumulate back end
// and output queue, plus the configuration register.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, sustained, on both the load
// and the nonzero stream, as long as row results are popped: the vector store
// has a single port with at most one access per request, and the back end does one
// registered 32x32 multiply and one 64-bit accumulate per cycle. A row result
// goes from the edge that accepts its end-of-row request into the middle
// queue, then into the multiply stage, then is accumulated and rounded into
// the output queue, where it can be popped; the middle queue holds it while
// the output queue has no room. Vector elements must be loaded before any
// nonzero reads them; the store is not cleared at reset. Set columns_in_use
// only while no requests are in flight.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_top
	import csm_pkg::*;
#(
	parameter int unsigned COLUMNS   = 4096,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire csm_in_t           item,
	output logic                   empty,
	input  wire logic              pop,
	output csm_out_t               result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int unsigned MCW = $clog2(MID_DEPTH+1);
	localparam int unsigned OCW = $clog2(OUT_DEPTH+1);

	logic [12:0]    cols_q;
	logic           cfg_wr;

	logic           mid_push;
	csm_mid_t       mid_data;
	logic           mid_pop;
	csm_mid_t       mid_head;
	logic           mid_empty;
	logic [MCW-1:0] mid_count;

	logic           out_push;
	csm_out_t       out_data;
	logic [OCW-1:0] out_count;
	logic [$bits(csm_out_t)-1:0] out_head;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_COLUMNS_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RESET;
		end else if (cfg_wr) begin
			cols_q <= pwdata[12:0];
		end
	end

	assign prdata = (paddr[2] == CFG_COLUMNS_IDX) ? {19'd0, cols_q} : 32'd0;

	csm_front #(
		.COLUMNS(COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cols     (cols_q),
		.mid_count(mid_count),
		.full     (full),
		.mid_push (mid_push),
		.mid_data (mid_data)
	);

	csm_queue #(
		.WIDTH($bits(csm_mid_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (mid_push),
		.push_data(mid_data),
		.pop      (mid_pop),
		.head     (mid_head),
		.empty    (mid_empty),
		.count    (mid_count)
	);

	csm_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_head (mid_head),
		.mid_empty(mid_empty),
		.out_count(out_count),
		.mid_pop  (mid_pop),
		.out_push (out_push),
		.out_data (out_data)
	);

	csm_queue #(
		.WIDTH($bits(csm_out_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (out_push),
		.push_data(out_data),
		.pop      (pop),
		.head     (out_head),
		.empty    (empty),
		.count    (out_count)
	);

	assign result = csm_out_t'(out_head);

endmodule : csr_sparse_matvec_top
`default_nettype wire

// ----- rtl/csm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csm_checker: port-level checks of the sparse matrix-vector block
// Watches the request, result and configuration ports; bound to the top.
// ----------------------------------------------------------------------------
module csm_checker
	import csm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              full,
	input wire logic              empty,
	input wire logic              pop,
	input wire csm_out_t          result,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [31:0]       prdata,
	input wire logic              pready
);

	// A waiting result holds until it is taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed or vanished before pop");

	// Saturation flag only with a clipped sum
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.saturated) |->
		(result.row_sum == 32'sh7fff_ffff || result.row_sum == 32'sh8000_0000))
		else $error("saturated set with unclipped row_sum");

	// Column count reads back within its 13 bits
	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && !pwrite) |-> (prdata[31:13] == 19'd0))
		else $error("configuration read has upper bits set");

	// Configuration write is taken in the access cycle
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable) |-> pready)
		else $error("pready low in access cycle");

	// Handshake flags are always driven out of reset
	a_flags_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty, pready}))
		else $error("full, empty or pready unknown");

endmodule : csm_checker

bind csr_sparse_matvec_top csm_checker u_chk (.*);
`default_nettype wire

// ----- test/csm_row_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_row_monitor: row-sum predictor and result check for the sparse mat-vec
// Watches the request, result and register ports. Keeps its own vector store,
// row accumulator, row count and column limit, predicts every row result and
// compares each popped result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module csm_row_monitor
	import csm_pkg::*;
#(
	parameter int unsigned COLUMNS   = 4096,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  csm_in_t           item,
	input  logic              empty,
	input  logic              pop,
	input  csm_out_t          result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int                mismatches,
	output int                sums_due
);

	localparam logic [CFG_AW-1:0] COLS_ADDR = CFG_AW'(4 * CFG_COLUMNS_IDX);
	localparam logic signed [63:0] Q_MAX    = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] Q_MIN    = 64'shFFFF_FFFF_8000_0000;
	localparam logic signed [63:0] HALF_LSB =
		(FRAC_BITS == 0) ? 64'sd0 : 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [31:0] vec_copy [COLUMNS];
	logic signed [63:0] dot_acc;
	logic [15:0]        row_idx;
	logic               skipped;
	logic [12:0]        cols_live;
	csm_out_t           sums_waiting[$];
	csm_out_t           oldest;

	// 64-bit add, clamped to the signed range
	function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %h actual %h", $time, name, want, got);
		return 1;
	endfunction

	// Apply one accepted request to the shadow state
	task automatic fold_request(input csm_in_t r);
		logic signed [63:0] a;
		logic signed [63:0] x;
		logic signed [63:0] q;
		csm_out_t           row;
		case (r.kind)
			KIND_LOAD: begin
				if (r.index < COLUMNS)
					vec_copy[r.index] = r.value;
				row_idx = '0;
				dot_acc = '0;
				skipped = 1'b0;
			end
			KIND_NZ: begin
				if (r.index < cols_live && r.index < COLUMNS) begin
					a = $signed(r.value);
					x = vec_copy[r.index];
					dot_acc = add_clamped(dot_acc, a * x);
				end else begin
					skipped = 1'b1;
				end
			end
			KIND_END: begin
				// round half up, then clip to Q16.16
				q = add_clamped(dot_acc, HALF_LSB) >>> FRAC_BITS;
				row.saturated  = (q > Q_MAX) || (q < Q_MIN);
				row.row_sum    = (q > Q_MAX) ? 32'h7FFF_FFFF :
					(q < Q_MIN) ? 32'h8000_0000 : q[31:0];
				row.row_number = row_idx;
				row.bad_column = skipped;
				sums_waiting = {sums_waiting, row};
				row_idx = row_idx + 16'd1;
				dot_acc = '0;
				skipped = 1'b0;
			end
			default: ; // spare kind: no effect
		endcase
	endtask

	// Per-edge monitor: results first, then register access, then requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_acc = '0;
			row_idx = '0;
			skipped = 1'b0;
			cols_live = COLUMNS_RESET;
			sums_waiting.delete();
			mismatches = 0;
			sums_due <= 0;
		end else begin
			if (pop && !empty) begin
				if (sums_waiting.size() == 0) begin
					$display("%0t: row result %h with none expected", $time, result);
					mismatches++;
				end else begin
					oldest = sums_waiting.pop_front();
					mismatches += field_diff("row_sum", oldest.row_sum, result.row_sum);
					mismatches += field_diff("row_number", 32'(oldest.row_number),
						32'(result.row_number));
					mismatches += field_diff("saturated", 32'(oldest.saturated),
						32'(result.saturated));
					mismatches += field_diff("bad_column", 32'(oldest.bad_column),
						32'(result.bad_column));
				end
			end
			if (psel && penable && pready && paddr == COLS_ADDR) begin
				if (pwrite)
					cols_live = pwdata[12:0];
				else
					mismatches += field_diff("columns_in_use readback",
						{19'd0, cols_live}, prdata);
			end
			if (push && !full)
				fold_request(item);
			sums_due <= sums_waiting.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for csr_sparse_matvec_top
// Directed rows hit rounding, clamping, empty rows, bad columns and abandoned
// rows; then three random phases at different column limits and idle rates
// stream vector loads and compressed rows. csm_row_monitor does the checking.
// ----------------------------------------------------------------------------
module tb;
	import csm_pkg::*;

	localparam logic [1:0]        KIND_SPARE  = 2'd3;
	localparam logic [CFG_AW-1:0] COLS_ADDR   = CFG_AW'(4 * CFG_COLUMNS_IDX);
	localparam int                DRAIN_GAP   = 8;
	localparam int                QUIET_LIMIT = 4000;
	localparam int unsigned       PHASE_HALF  = 100;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              push    = 1'b0;
	csm_in_t           item    = '0;
	logic              pop     = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [CFG_AW-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic              full;
	logic              empty;
	logic              pready;
	csm_out_t          result;
	logic [31:0]       prdata;
	int                mismatches;
	int                sums_due;

	int          send_idle_pct = 15;
	int          pop_idle_pct  = 46;
	int          quiet         = 0;
	int unsigned sent          = 0;
	int unsigned col_limit     = 4096;
	logic [11:0] loaded_cols[$];

	csr_sparse_matvec_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	csm_row_monitor u_rows (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.mismatches (mismatches),
		.sums_due   (sums_due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: random back-pressure
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= pop_idle_pct);
	end

	// Watchdog: cycles in a row with nothing accepted
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic csm_in_t req_of(input logic [1:0] k, input logic [11:0] i,
			input logic [31:0] v);
		csm_in_t r;
		r.kind  = k;
		r.index = i;
		r.value = v;
		return r;
	endfunction

	// Mostly small fixed-point values, some wide, some at the extremes
	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = {{14{v[17]}}, v[17:0]};
			5, 6:          v = {{8{v[23]}}, v[23:0]};
			7:             ;
			default: begin
				case ($urandom_range(4))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = 32'h0000_0000;
					3:       v = 32'h0000_0001;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		return v;
	endfunction

	// Column of a nonzero: loaded and in range, or now and then out of range
	function automatic logic [11:0] pick_column();
		int unsigned c;
		if (col_limit < 4096 && $urandom_range(99) < 12)
			return 12'($urandom_range(4095, col_limit));
		repeat (6) begin
			c = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
			if (c < col_limit)
				return 12'(c);
		end
		return 12'($urandom_range(col_limit < 8 ? col_limit - 1 : 7));
	endfunction

	task automatic put_request(input csm_in_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (r.kind != KIND_SPARE)
			sent++;
		if (r.kind == KIND_LOAD)
			loaded_cols = {loaded_cols, r.index};
	endtask

	// Hold off until every row result is out and the pipe is quiet
	task automatic settle();
		push <= 1'b0;
		do
			@(posedge clk);
		while (sums_due != 0);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// Write the column limit, then read it back
	task automatic set_columns(input int unsigned cols);
		col_limit = (cols < 4096) ? cols : 4096;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= COLS_ADDR;
		pwdata  <= 32'(cols);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned cols, input int send_pct,
			input int recv_pct);
		int unsigned goal;
		int unsigned pick;
		send_idle_pct = send_pct;
		pop_idle_pct <= recv_pct;
		set_columns(cols);
		// low columns always loaded so rows can find in-range entries
		for (int i = 0; i < 8 && i < int'(col_limit); i++)
			put_request(req_of(KIND_LOAD, 12'(i), rand_value()));
		repeat (8) put_request(req_of(KIND_LOAD, 12'($urandom_range(4095)), rand_value()));
		repeat (2) begin
			goal = sent + PHASE_HALF;
			while (sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					repeat ($urandom_range(6, 1))
						put_request(req_of(KIND_LOAD, $urandom_range(1) ?
							12'($urandom_range(4095)) : 12'($urandom_range(col_limit - 1)),
							rand_value()));
				end else if (pick < 11) begin
					put_request(req_of(KIND_SPARE, 12'($urandom), $urandom));
				end else if (pick < 14) begin
					// row cut short by a vector load
					repeat ($urandom_range(3, 1))
						put_request(req_of(KIND_NZ, pick_column(), rand_value()));
					put_request(req_of(KIND_LOAD, 12'($urandom_range(4095)), rand_value()));
				end else begin
					repeat ($urandom_range(6))
						put_request(req_of(KIND_NZ, pick_column(), rand_value()));
					put_request(req_of(KIND_END, 12'($urandom), $urandom));
				end
			end
			settle();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset column limit
		put_request(req_of(KIND_LOAD, 12'd0, 32'h0000_0001));
		put_request(req_of(KIND_LOAD, 12'd4095, 32'h8000_0000));
		put_request(req_of(KIND_LOAD, 12'd1, 32'h7FFF_FFFF));
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));        // empty row
		put_request(req_of(KIND_NZ, 12'd0, 32'h0000_8000));         // +half rounds up
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));
		put_request(req_of(KIND_NZ, 12'd0, 32'hFFFF_8000));         // -half rounds to zero
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));
		repeat (3) put_request(req_of(KIND_NZ, 12'd4095, 32'h8000_0000)); // acc clamps high
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));
		repeat (3) put_request(req_of(KIND_NZ, 12'd1, 32'h8000_0000));    // acc clamps low
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));
		put_request(req_of(KIND_NZ, 12'd1, 32'h7FFF_FFFF));         // Q16.16 clip
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));
		put_request(req_of(KIND_SPARE, 12'hFFF, 32'hFFFF_FFFF));
		put_request(req_of(KIND_END, 12'hFFF, 32'hFFFF_FFFF));
		settle();

		// Single column in use: skipped nonzero, then a row dropped by a load
		set_columns(1);
		put_request(req_of(KIND_NZ, 12'd4095, 32'h0001_0000));
		put_request(req_of(KIND_NZ, 12'd0, 32'h0001_0000));
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));
		put_request(req_of(KIND_NZ, 12'd0, 32'h0001_0000));
		put_request(req_of(KIND_LOAD, 12'd2, 32'h0001_0000));
		put_request(req_of(KIND_END, 12'd0, 32'h0000_0000));
		settle();

		random_phase($urandom_range(4095, 2), 15, 46);
		random_phase(4096, 46, 15);
		random_phase($urandom_range(64, 1), 0, 0);

		if (mismatches == 0 && sums_due == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/csm_pkg.sv
rtl/csm_queue.sv
rtl/csm_front.sv
rtl/csm_back.sv
rtl/csr_sparse_matvec_top.sv
rtl/csm_checker.sv
test/csm_row_monitor.sv
test/tb.sv
